FILE: hw/rtl/tsq_pkg.sv
// Shared types and constants for the timestamp-ordered event queue.
// Used by tsq_mem, tsq_cmp and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tsq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int OP_W    = 3;
  localparam int TIME_W  = 31;
  localparam int PID_W   = 8;
  localparam int TRANS_W = 4;
  localparam int STATE_W = 3;
  localparam int STAT_W  = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0]  t;
    logic [PID_W-1:0]   pid;
    logic [TRANS_W-1:0] trans;
    logic [STATE_W-1:0] from_st;
    logic [STATE_W-1:0] to_st;
  } evt_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    evt_t             wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic lt;
    logic pid_eq;
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tsq_mem.sv
// Event slot store: one write port, one registered read port.
// Depends on tsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsq_mem (
  input  logic              clk,
  input  tsq_pkg::mem_req_t req,
  output tsq_pkg::evt_t     rdata
);
  import tsq_pkg::*;

  evt_t slots [DEPTH];
  evt_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      slots[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= slots[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/tsq_cmp.sv
// Shared compare unit: time ordering and pid match against one stored word.
// Depends on tsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsq_cmp (
  input  logic [tsq_pkg::TIME_W-1:0] a_time,
  input  logic [tsq_pkg::TIME_W-1:0] b_time,
  input  logic [tsq_pkg::PID_W-1:0]  a_pid,
  input  logic [tsq_pkg::PID_W-1:0]  b_pid,
  output tsq_pkg::cmp_res_t          res
);
  import tsq_pkg::*;

  // strictly-less keeps equal timestamps in arrival order
  assign res.lt     = (a_time < b_time);
  assign res.pid_eq = (a_pid == b_pid);

endmodule

`default_nettype wire

FILE: hw/rtl/timestamp_ordered_event_queue_unit.sv
// Top level of the timestamp-ordered event queue: sequencer, slot store
// and shared compare unit. Depends on tsq_pkg, tsq_mem and tsq_cmp.
`timescale 1ns / 1ps
`default_nettype none

// Sorted event queue of tsq_pkg::DEPTH slots, ordered by timestamp with
// ties kept in arrival order. Raise start with an operation while busy is
// low; the word is taken at that edge and busy stays high until the work
// is done. Every operation returns exactly one result word, shown for a
// single cycle with out_strobe high; the receiver cannot stall it, so
// capture it on that cycle. busy is low again when the strobe appears, so
// a new word may be issued in the same cycle. Cycle cost is set by the one
// read port of the slot store, which reads one slot at a time: insert
// walks down from the tail and moves each later event up one slot; peek
// and pop find slot 0, lookup scans up from slot 0 for the pid and a miss
// reads every stored event; pop and remove then close the gap by moving
// each later event down one slot. Full insert and unused codes answer at once.
// No clearing pass is needed after reset.
module timestamp_ordered_event_queue_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tsq_pkg::OP_W-1:0]    in_operation,
  input  logic [tsq_pkg::TIME_W-1:0]  in_event_time,
  input  logic [tsq_pkg::PID_W-1:0]   in_proc_id,
  input  logic [tsq_pkg::TRANS_W-1:0] in_transition_code,
  input  logic [tsq_pkg::STATE_W-1:0] in_from_state,
  input  logic [tsq_pkg::STATE_W-1:0] in_to_state,
  output logic                        out_strobe,
  output logic [tsq_pkg::STAT_W-1:0]  out_status,
  output logic [tsq_pkg::TIME_W-1:0]  out_time,
  output logic [tsq_pkg::PID_W-1:0]   out_proc_id,
  output logic [tsq_pkg::TRANS_W-1:0] out_transition,
  output logic [tsq_pkg::STATE_W-1:0] out_from_state,
  output logic [tsq_pkg::STATE_W-1:0] out_to_state
);
  import tsq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CHK = 3'd4;
  localparam logic [2:0] S_SHIFT_RD = 3'd5;
  localparam logic [2:0] S_SHIFT_WR = 3'd6;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;      // number of stored events
  logic [CNT_W-1:0]  idx_r, idx_nxt;      // slot under work
  logic [OP_W-1:0]   op_r, op_nxt;
  evt_t              key_r, key_nxt;      // word to insert, search key, then removed event
  logic              strobe_r, strobe_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  evt_t              res_r, res_nxt;

  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_dec;
  logic              hit;
  logic              drops;

  mem_req_t          mem_req;
  evt_t              rdata;
  cmp_res_t          cmp;

  tsq_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // one compare unit serves the insert walk and the pid scan
  tsq_cmp u_cmp (
    .a_time (key_r.t),
    .b_time (rdata.t),
    .a_pid  (key_r.pid),
    .b_pid  (rdata.pid),
    .res    (cmp)
  );

  assign idx_inc = idx_r + 1'b1;
  assign idx_dec = idx_r - 1'b1;
  assign drops   = (op_r == OP_POP) || (op_r == OP_REMOVE);
  // pop and peek take the head; lookup and remove need a pid match
  assign hit     = (op_r == OP_POP) || (op_r == OP_PEEK) || cmp.pid_eq;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    res_nxt    = res_r;

    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r[IDX_W-1:0];
    mem_req.wdata = key_r;
    mem_req.raddr = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt        = in_operation;
          key_nxt.t     = in_event_time;
          key_nxt.pid   = in_proc_id;
          key_nxt.trans = in_transition_code;
          key_nxt.from_st = in_from_state;
          key_nxt.to_st = in_to_state;
          case (in_operation)
            OP_INSERT: begin
              if (cnt_r == FULL_CNT) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_FULL;
                res_nxt    = '0;
              end else begin
                idx_nxt   = cnt_r;
                state_nxt = S_INS_RD;
              end
            end
            OP_POP, OP_PEEK, OP_LOOKUP, OP_REMOVE: begin
              idx_nxt   = '0;
              state_nxt = S_SCAN_RD;
            end
            default: begin
              // unused codes: answer ok, touch nothing
              strobe_nxt = 1'b1;
              status_nxt = ST_OK;
              res_nxt    = '0;
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (idx_r == '0) begin
          // walked to the head: the new word goes first
          mem_req.we = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
          strobe_nxt = 1'b1;
          status_nxt = ST_OK;
          res_nxt    = '0;
          state_nxt  = S_IDLE;
        end else begin
          mem_req.raddr = idx_dec[IDX_W-1:0];
          state_nxt     = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        mem_req.we = 1'b1;
        if (cmp.lt) begin
          // move the later event up one slot and keep walking down
          mem_req.wdata = rdata;
          idx_nxt       = idx_dec;
          state_nxt     = S_INS_RD;
        end else begin
          cnt_nxt    = cnt_r + 1'b1;
          strobe_nxt = 1'b1;
          status_nxt = ST_OK;
          res_nxt    = '0;
          state_nxt  = S_IDLE;
        end
      end

      S_SCAN_RD: begin
        if (idx_r == cnt_r) begin
          // empty queue or pid absent
          strobe_nxt = 1'b1;
          status_nxt = ST_MISS;
          res_nxt    = '0;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (hit) begin
          if (drops) begin
            key_nxt   = rdata;
            state_nxt = S_SHIFT_RD;
          end else begin
            strobe_nxt = 1'b1;
            status_nxt = ST_OK;
            res_nxt    = '0;
            res_nxt.t  = rdata.t;
            state_nxt  = S_IDLE;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN_RD;
        end
      end

      S_SHIFT_RD: begin
        if (idx_inc >= cnt_r) begin
          // gap closed: drop the tail slot and hand out the removed event
          cnt_nxt    = cnt_r - 1'b1;
          strobe_nxt = 1'b1;
          status_nxt = ST_OK;
          res_nxt    = key_r;
          state_nxt  = S_IDLE;
        end else begin
          mem_req.raddr = idx_inc[IDX_W-1:0];
          state_nxt     = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = rdata;
        idx_nxt       = idx_inc;
        state_nxt     = S_SHIFT_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      idx_r    <= '0;
      op_r     <= OP_INSERT;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      op_r     <= op_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_time       = res_r.t;
  assign out_proc_id    = res_r.pid;
  assign out_transition = res_r.trans;
  assign out_from_state = res_r.from_st;
  assign out_to_state   = res_r.to_st;

endmodule

`default_nettype wire
